/* hw/rtl/supply_voltage_window_monitor_defines.svh */
// Assertion macros shared by the supply voltage window monitor RTL.
`ifndef SUPPLY_VOLTAGE_WINDOW_MONITOR_DEFINES_SVH
`define SUPPLY_VOLTAGE_WINDOW_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SVWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SVWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVWM_ASSERT(lbl, prop, msg)
`define SVWM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/svwm_pkg.sv */
// Types and constants of the supply voltage window monitor.
`timescale 1ns / 1ps

package svwm_pkg;

    localparam int RAW_W     = 16;
    localparam int LEVEL_W   = 12;
    localparam int CNT_W     = 4;
    localparam int SUM_W     = 14;
    localparam int PHASE_W   = 2;
    localparam int NUM_REGS  = 8;
    localparam int NUM_CMP   = 4;
    localparam int CFG_IDX_W = 3;

    // floor(raw*100/1805) == (raw*SCALE_MUL) >> SCALE_SHIFT, exact for 16-bit raw
    localparam int MUL_W       = 21;
    localparam int SCALE_SHIFT = 25;
    localparam logic [MUL_W-1:0] SCALE_MUL = 21'd1858972;
    localparam int PROD_W      = RAW_W + MUL_W;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef level_t level_arr_t [NUM_REGS];
    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW_ENTER  = 3'd0,
        REG_RESET_LOW_EXIT   = 3'd1,
        REG_WARN_LOW_ENTER   = 3'd2,
        REG_WARN_LOW_EXIT    = 3'd3,
        REG_WARN_HIGH_ENTER  = 3'd4,
        REG_WARN_HIGH_EXIT   = 3'd5,
        REG_RESET_HIGH_ENTER = 3'd6,
        REG_RESET_HIGH_EXIT  = 3'd7
    } cfg_reg_e;

    localparam int CMP_RESET_LOW  = 0;
    localparam int CMP_WARN_LOW   = 1;
    localparam int CMP_WARN_HIGH  = 2;
    localparam int CMP_RESET_HIGH = 3;

    // below flags out of reset, bit per comparator
    localparam logic [NUM_CMP-1:0] BELOW_RESET = 4'b1100;

    function automatic level_t level_reset(input cfg_reg_e idx);
        level_t val;
        case (idx)
            REG_RESET_LOW_ENTER:  val = 12'd500;
            REG_RESET_LOW_EXIT:   val = 12'd550;
            REG_WARN_LOW_ENTER:   val = 12'd600;
            REG_WARN_LOW_EXIT:    val = 12'd650;
            REG_WARN_HIGH_ENTER:  val = 12'd2600;
            REG_WARN_HIGH_EXIT:   val = 12'd2650;
            REG_RESET_HIGH_ENTER: val = 12'd2650;
            REG_RESET_HIGH_EXIT:  val = 12'd2700;
            default:              val = '0;
        endcase
        return val;
    endfunction

endpackage

/* hw/rtl/svwm_if.sv */
// Valid/ready channels of the supply voltage window monitor.
`timescale 1ns / 1ps

interface svwm_sample_if;
    logic                      valid;
    logic                      ready;
    logic [svwm_pkg::RAW_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface svwm_result_if;
    logic                        valid;
    logic                        ready;
    logic [svwm_pkg::LEVEL_W-1:0] volts_now;
    logic [svwm_pkg::LEVEL_W-1:0] volts_mean;
    logic                        reset_low_flag;
    logic                        warn_low_flag;
    logic                        warn_high_ok;
    logic                        reset_high_ok;
    logic                        mute_request;
    logic                        reset_request;

    modport source (
        output valid, output volts_now, output volts_mean, output reset_low_flag,
        output warn_low_flag, output warn_high_ok, output reset_high_ok,
        output mute_request, output reset_request, input ready
    );
    modport sink (
        input valid, input volts_now, input volts_mean, input reset_low_flag,
        input warn_low_flag, input warn_high_ok, input reset_high_ok,
        input mute_request, input reset_request, output ready
    );
endinterface

/* hw/rtl/svwm_cfg_regs.sv */
// Threshold register file written through the configuration port.
`timescale 1ns / 1ps

module svwm_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [svwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svwm_pkg::LEVEL_W-1:0]   cfg_data,
    output svwm_pkg::level_arr_t          levels
);
    import svwm_pkg::*;

    level_t levels_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                levels_reg[i] <= level_reset(cfg_reg_e'(i[CFG_IDX_W-1:0]));
            end
        end
        else if (cfg_we)
        begin
            levels_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            levels[i] = levels_reg[i];
        end
    end

endmodule

/* hw/rtl/svwm_scale.sv */
// Input stage: raw sample to centivolts by reciprocal multiply.
`timescale 1ns / 1ps

module svwm_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [svwm_pkg::RAW_W-1:0]   raw,
    input  logic                        advance,
    output logic                        stage_valid,
    output logic [svwm_pkg::LEVEL_W-1:0] volts
);
    import svwm_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    level_t            volts_reg;
    logic [PROD_W-1:0] product;
    logic              take;

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;
    assign product  = PROD_W'(raw) * PROD_W'(SCALE_MUL);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            volts_reg <= product[SCALE_SHIFT +: LEVEL_W];
        end
    end

    assign stage_valid = valid_reg;
    assign volts       = volts_reg;

endmodule

/* hw/rtl/svwm_comparator.sv */
// One debounced hysteresis comparator.
`timescale 1ns / 1ps

`include "supply_voltage_window_monitor_defines.svh"

module svwm_comparator #(
    parameter int   LIMIT      = 6,
    parameter logic FLAG_RESET = 1'b0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [svwm_pkg::LEVEL_W-1:0] volts,
    input  logic [svwm_pkg::LEVEL_W-1:0] enter_lvl,
    input  logic [svwm_pkg::LEVEL_W-1:0] exit_lvl,
    output logic                        below
);
    import svwm_pkg::*;

    localparam count_t LIM = CNT_W'(LIMIT);

    logic   flag_reg;
    logic   flag_next;
    count_t cnt_reg;
    count_t cnt_next;
    logic   toward;

    // clear flag looks under enter, set flag looks over exit
    assign toward = flag_reg ? (volts > exit_lvl) : (volts < enter_lvl);

    always_comb
    begin
        flag_next = flag_reg;
        cnt_next  = cnt_reg;
        if (en)
        begin
            if (toward)
            begin
                if (cnt_reg == '0)
                begin
                    cnt_next  = LIM;
                    flag_next = !flag_reg;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            else if (cnt_reg < LIM)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= FLAG_RESET;
            cnt_reg  <= LIM;
        end
        else
        begin
            flag_reg <= flag_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign below = flag_reg;

    `SVWM_ASSERT_ALWAYS(a_cnt_in_range, cnt_reg <= LIM, "debounce count above limit")
    `SVWM_ASSERT(a_flip_from_zero, (flag_reg != $past(flag_reg)) |-> ($past(cnt_reg) == '0 && cnt_reg == LIM), "flag flipped without expired count")
    `SVWM_ASSERT(a_idle_holds, !$past(en) |-> ($stable(cnt_reg) && $stable(flag_reg)), "comparator state moved without a beat")

endmodule

/* hw/rtl/svwm_mean.sv */
// Four-sample window average.
`timescale 1ns / 1ps

module svwm_mean (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [svwm_pkg::LEVEL_W-1:0] volts,
    output logic [svwm_pkg::LEVEL_W-1:0] mean
);
    import svwm_pkg::*;

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]   sum_add;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    level_t             mean_reg;
    level_t             mean_next;

    assign sum_add = sum_reg + SUM_W'(volts);

    always_comb
    begin
        sum_next   = sum_reg;
        phase_next = phase_reg;
        mean_next  = mean_reg;
        if (en)
        begin
            phase_next = phase_reg + 1'b1;
            sum_next   = sum_add;
            // fourth beat of the window publishes and restarts
            if (phase_next == '0)
            begin
                mean_next = sum_add[SUM_W-1:2];
                sum_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            phase_reg <= '0;
            mean_reg  <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            phase_reg <= phase_next;
            mean_reg  <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

/* hw/rtl/supply_voltage_window_monitor.sv */
// Supply voltage window monitor: four debounced comparators and a mean.
// Takes one converter sample per cycle when the result side keeps up. A sample
// is scaled to centivolts in the input register (one 16x21 reciprocal multiply),
// and the comparators, the four-sample mean and the result register update when
// the sample advances out of the input register, which waits while an unaccepted
// result is held. Throughput is one sample per cycle while results are taken; a
// stalled result holds while the input register takes one more sample behind it.
`timescale 1ns / 1ps

module supply_voltage_window_monitor #(
    parameter int DEBOUNCE_RESET   = 6,
    parameter int DEBOUNCE_WARNING = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    svwm_sample_if.sink                   sample,
    svwm_result_if.source                 result,
    input  logic                          cfg_we,
    input  logic [svwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svwm_pkg::LEVEL_W-1:0]   cfg_data
);
    import svwm_pkg::*;

    level_arr_t        levels;
    logic              stage_valid;
    level_t            volts;
    logic              advance;
    logic              out_valid_reg;
    logic              out_valid_next;
    level_t            volts_now_reg;
    level_t            mean;
    logic [NUM_CMP-1:0] below;

    svwm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .levels    (levels)
    );

    svwm_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sample.valid),
        .in_ready    (sample.ready),
        .raw         (sample.adc_sample),
        .advance     (advance),
        .stage_valid (stage_valid),
        .volts       (volts)
    );

    assign advance = stage_valid && (!out_valid_reg || result.ready);

    for (genvar k = 0; k < NUM_CMP; k++)
    begin : g_cmp
        svwm_comparator #(
            .LIMIT      ((k == CMP_WARN_LOW) ? DEBOUNCE_WARNING : DEBOUNCE_RESET),
            .FLAG_RESET (BELOW_RESET[k])
        ) u_cmp (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .volts     (volts),
            .enter_lvl (levels[2*k]),
            .exit_lvl  (levels[2*k+1]),
            .below     (below[k])
        );
    end

    svwm_mean u_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .volts (volts),
        .mean  (mean)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            volts_now_reg <= volts;
        end
    end

    // flags and mean are the state itself, updated on the same beat as volts_now
    assign result.valid          = out_valid_reg;
    assign result.volts_now      = volts_now_reg;
    assign result.volts_mean     = mean;
    assign result.reset_low_flag = below[CMP_RESET_LOW];
    assign result.warn_low_flag  = below[CMP_WARN_LOW];
    assign result.warn_high_ok   = below[CMP_WARN_HIGH];
    assign result.reset_high_ok  = below[CMP_RESET_HIGH];
    assign result.mute_request   = below[CMP_WARN_LOW] || !below[CMP_WARN_HIGH];
    assign result.reset_request  = below[CMP_RESET_LOW];

endmodule

/* tb/supply_voltage_window_monitor_test.sv */
// Self-checking testbench of the supply voltage window monitor.
`timescale 1ns / 1ps

module supply_voltage_window_monitor_test;
    import svwm_pkg::*;

    localparam count_t DEBOUNCE_RESET_LIM   = 4'd6;
    localparam count_t DEBOUNCE_WARNING_LIM = 4'd12;
    localparam int     MAX_CENTIVOLTS       = 3630;
    localparam int     LONG_HOLD_CYCLES     = 60;
    localparam int     WATCHDOG_LIMIT       = 1000;

    typedef struct packed {
        level_t volts_now;
        level_t volts_mean;
        logic   reset_low_flag;
        logic   warn_low_flag;
        logic   warn_high_ok;
        logic   reset_high_ok;
        logic   mute_request;
        logic   reset_request;
    } supply_status_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    level_t               cfg_data;

    svwm_sample_if sample_ch ();
    svwm_result_if result_ch ();

    supply_voltage_window_monitor #(
        .DEBOUNCE_RESET   (DEBOUNCE_RESET_LIM),
        .DEBOUNCE_WARNING (DEBOUNCE_WARNING_LIM)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    level_t               level_cfg [NUM_REGS];
    logic [NUM_CMP-1:0]   below_now;
    count_t               debounce_left [NUM_CMP];
    logic [SUM_W-1:0]     window_acc;
    logic [PHASE_W-1:0]   window_pos;
    level_t               mean_last;

    logic [RAW_W-1:0]     samples_pending [$];
    supply_status_t       expected_status [$];
    int unsigned          items_issued;
    int unsigned          inputs_accepted;
    int unsigned          results_seen;
    int unsigned          mismatches;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;
    logic                 sender_hold;
    logic                 hold_request;
    int unsigned          hold_left;
    logic                 sample_beat;
    int unsigned          quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic supply_status_t track_supply(input logic [RAW_W-1:0] raw);
        int unsigned    scaled;
        level_t         cv;
        count_t         lim;
        logic           toward;
        supply_status_t st;
        scaled = (int'(raw) * 100) / 1805;
        cv = scaled[LEVEL_W-1:0];
        window_acc = window_acc + cv;
        window_pos = window_pos + 1'b1;
        if (window_pos == '0)
        begin
            mean_last = window_acc[SUM_W-1:2];
            window_acc = '0;
        end
        for (int k = 0; k < NUM_CMP; k++)
        begin
            lim = (k == CMP_WARN_LOW) ? DEBOUNCE_WARNING_LIM : DEBOUNCE_RESET_LIM;
            if (!below_now[k])
                toward = (cv < level_cfg[2*k]);
            else
                toward = (cv > level_cfg[2*k+1]);
            if (toward)
            begin
                // one step past zero flips the flag
                if (debounce_left[k] == '0)
                begin
                    debounce_left[k] = lim;
                    below_now[k] = ~below_now[k];
                end
                else
                    debounce_left[k] = debounce_left[k] - 1'b1;
            end
            else if (debounce_left[k] < lim)
                debounce_left[k] = debounce_left[k] + 1'b1;
        end
        st.volts_now      = cv;
        st.volts_mean     = mean_last;
        st.reset_low_flag = below_now[CMP_RESET_LOW];
        st.warn_low_flag  = below_now[CMP_WARN_LOW];
        st.warn_high_ok   = below_now[CMP_WARN_HIGH];
        st.reset_high_ok  = below_now[CMP_RESET_HIGH];
        st.mute_request   = below_now[CMP_WARN_LOW] | ~below_now[CMP_WARN_HIGH];
        st.reset_request  = below_now[CMP_RESET_LOW];
        return st;
    endfunction

    function automatic void check_field(input string name, input level_t want,
                                        input level_t got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || sample_beat)
        begin
            if (samples_pending.size() != 0 && !sender_hold &&
                $urandom_range(99) >= send_idle_pct)
            begin
                sample_ch.valid      <= 1'b1;
                sample_ch.adc_sample <= samples_pending.pop_front();
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: register writes, result checks, predictions
    always @(posedge clk)
    begin
        supply_status_t want;
        sample_beat <= sample_ch.valid && sample_ch.ready;
        if (rst_n)
        begin
            if (cfg_we)
                level_cfg[cfg_index] = cfg_data;
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_status.size() == 0)
                begin
                    mismatches++;
                    $error("result beat with no sample outstanding");
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("volts_now", want.volts_now, result_ch.volts_now);
                    check_field("volts_mean", want.volts_mean, result_ch.volts_mean);
                    check_field("reset_low_flag", want.reset_low_flag,
                                result_ch.reset_low_flag);
                    check_field("warn_low_flag", want.warn_low_flag,
                                result_ch.warn_low_flag);
                    check_field("warn_high_ok", want.warn_high_ok, result_ch.warn_high_ok);
                    check_field("reset_high_ok", want.reset_high_ok,
                                result_ch.reset_high_ok);
                    check_field("mute_request", want.mute_request, result_ch.mute_request);
                    check_field("reset_request", want.reset_request,
                                result_ch.reset_request);
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                inputs_accepted++;
                expected_status.push_back(track_supply(sample_ch.adc_sample));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("supply_voltage_window_monitor_test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_sample(input logic [RAW_W-1:0] raw);
        samples_pending.push_back(raw);
        items_issued++;
    endtask

    function automatic logic [RAW_W-1:0] raw_for(input int cv);
        int clamped;
        clamped = (cv < 0) ? 0 : (cv > MAX_CENTIVOLTS) ? MAX_CENTIVOLTS : cv;
        return RAW_W'((clamped * 1805 + 99) / 100);
    endfunction

    // runs of samples dwelling near a threshold or at a random level, with jitter and some noise
    task automatic queue_runs(input int count);
        int n;
        int pick;
        int center;
        int run_len;
        int cv;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                queue_sample(RAW_W'($urandom_range(65535)));
                n++;
            end
            else
            begin
                if (pick < 80)
                    center = int'(level_cfg[$urandom_range(NUM_REGS-1)]) +
                             int'($urandom_range(8)) - 4;
                else
                    center = $urandom_range(MAX_CENTIVOLTS);
                run_len = (pick < 50) ? $urandom_range(30, 1) : $urandom_range(16, 1);
                for (int j = 0; j < run_len && n < count; j++)
                begin
                    cv = center;
                    if ($urandom_range(3) == 0)
                        cv = cv + int'($urandom_range(6)) - 3;
                    queue_sample(raw_for(cv));
                    n++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (results_seen != items_issued);
    endtask

    task automatic write_level(input cfg_reg_e idx, input level_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic program_levels(input level_t vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
            write_level(cfg_reg_e'(i), vals[i]);
    endtask

    initial
    begin
        level_t levels [NUM_REGS];
        int     lo;
        int     hi;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        result_ch.ready      = 1'b0;
        sample_beat          = 1'b0;
        sender_hold          = 1'b0;
        hold_request         = 1'b0;
        hold_left            = 0;
        quiet_cycles         = 0;
        items_issued         = 0;
        inputs_accepted      = 0;
        results_seen         = 0;
        mismatches           = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        level_cfg[REG_RESET_LOW_ENTER]  = 12'd500;
        level_cfg[REG_RESET_LOW_EXIT]   = 12'd550;
        level_cfg[REG_WARN_LOW_ENTER]   = 12'd600;
        level_cfg[REG_WARN_LOW_EXIT]    = 12'd650;
        level_cfg[REG_WARN_HIGH_ENTER]  = 12'd2600;
        level_cfg[REG_WARN_HIGH_EXIT]   = 12'd2650;
        level_cfg[REG_RESET_HIGH_ENTER] = 12'd2650;
        level_cfg[REG_RESET_HIGH_EXIT]  = 12'd2700;
        below_now = 4'b1100;
        for (int k = 0; k < NUM_CMP; k++)
            debounce_left[k] = (k == CMP_WARN_LOW) ? DEBOUNCE_WARNING_LIM
                                                   : DEBOUNCE_RESET_LIM;
        window_acc = '0;
        window_pos = '0;
        mean_last  = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // levels out of reset: extremes, then long dwells at both ends of the range
        queue_sample(16'h0000);
        queue_sample(16'hFFFF);
        queue_sample(16'h5555);
        queue_sample(16'hAAAA);
        queue_sample(16'h0001);
        queue_sample(16'hFFFE);
        repeat (13) queue_sample(16'h0000);
        repeat (7) queue_sample(16'hFFFF);
        queue_runs(150);
        wait_drained();

        // ordered windows at random places, sender idling
        for (int k = 0; k < NUM_CMP; k++)
        begin
            lo = $urandom_range(MAX_CENTIVOLTS - 200);
            hi = lo + $urandom_range(120, 1);
            levels[2*k]   = level_t'(lo);
            levels[2*k+1] = level_t'(hi);
        end
        program_levels(levels);
        send_idle_pct = 61;
        queue_runs(250);
        wait_drained();

        // all levels at zero, receiver stalling
        for (int i = 0; i < NUM_REGS; i++)
            levels[i] = '0;
        program_levels(levels);
        send_idle_pct  = 0;
        recv_stall_pct = 61;
        queue_runs(150);
        wait_drained();

        // all levels at full scale, both sides idling
        for (int i = 0; i < NUM_REGS; i++)
            levels[i] = '1;
        program_levels(levels);
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        queue_runs(150);
        wait_drained();

        // crossed levels: enter above exit
        for (int k = 0; k < NUM_CMP; k++)
        begin
            lo = $urandom_range(MAX_CENTIVOLTS - 200);
            hi = lo + $urandom_range(150, 1);
            levels[2*k]   = level_t'(hi);
            levels[2*k+1] = level_t'(lo);
        end
        program_levels(levels);
        queue_runs(250);
        wait_drained();

        // reset levels written back; long receiver hold-off, then a sender pause
        levels[REG_RESET_LOW_ENTER]  = 12'd500;
        levels[REG_RESET_LOW_EXIT]   = 12'd550;
        levels[REG_WARN_LOW_ENTER]   = 12'd600;
        levels[REG_WARN_LOW_EXIT]    = 12'd650;
        levels[REG_WARN_HIGH_ENTER]  = 12'd2600;
        levels[REG_WARN_HIGH_EXIT]   = 12'd2650;
        levels[REG_RESET_HIGH_ENTER] = 12'd2650;
        levels[REG_RESET_HIGH_EXIT]  = 12'd2700;
        program_levels(levels);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_runs(120);
        hold_request = 1'b1;
        wait_drained();
        queue_runs(120);
        do @(negedge clk); while (results_seen + 60 > items_issued);
        sender_hold = 1'b1;
        do @(negedge clk); while (sample_ch.valid || results_seen != inputs_accepted);
        sender_hold = 1'b0;
        queue_runs(100);
        wait_drained();

        repeat (8) @(negedge clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("supply_voltage_window_monitor_test passed");
        else
            $display("supply_voltage_window_monitor_test failed");
        $finish;
    end

endmodule
